@@ hdl/flash_page_buffer_planner_defines.svh @@
// Assertion macros shared by the page buffer planner modules.
// Needs no other file; SYNTHESIS selects the empty bodies.
`ifndef FLASH_PAGE_BUFFER_PLANNER_DEFINES_SVH
`define FLASH_PAGE_BUFFER_PLANNER_DEFINES_SVH

`ifndef SYNTHESIS

`define FPBP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fpbp assertion failed");

`define FPBP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fpbp assertion failed");

`else

`define FPBP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FPBP_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/fpbp_pkg.sv @@
// Package of the page buffer planner: geometry, widths, opcodes and types.
// Used by every module of the block; depends on nothing.
package fpbp_pkg;

  localparam int unsigned PAGE_BYTES   = 264;
  localparam int unsigned PAGE_COUNT   = 2048;
  localparam int unsigned MAX_REQUEST  = 512;
  localparam int unsigned DEVICE_BYTES = PAGE_BYTES * PAGE_COUNT;

  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned PAGE_W   = 11;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned LENGTH_W = 10;
  localparam int unsigned DSTART_W = 9;
  localparam int unsigned BPAGE_W  = PAGE_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [7:0] opcode_t;

  localparam opcode_t OP_NONE     = 8'h00;
  localparam opcode_t OP_FILL1    = 8'h53;
  localparam opcode_t OP_FILL2    = 8'h55;
  localparam opcode_t OP_FLUSH1   = 8'h83;
  localparam opcode_t OP_FLUSH2   = 8'h86;
  localparam opcode_t OP_ERASE    = 8'h81;
  localparam opcode_t OP_WBUF1    = 8'h84;
  localparam opcode_t OP_WBUF2    = 8'h87;
  localparam opcode_t OP_READ_MEM = 8'hE8;

  typedef struct packed {
    logic                err;
    logic                act;
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } job_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [PAGE_W-1:0]   page;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [DSTART_W-1:0] data_start;
    logic                error;
    logic                last;
  } result_t;

endpackage

@@ hdl/fpbp_front.sv @@
// Front end of the page buffer planner: accepts requests, checks bounds and
// splits the address into page and offset. Depends on fpbp_pkg.
`include "flash_page_buffer_planner_defines.svh"

module fpbp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic                         s_action_i,
  input  logic [fpbp_pkg::ADDR_W-1:0]  s_address_i,
  input  logic [fpbp_pkg::COUNT_W-1:0] s_count_i,
  output logic                         push_o,
  output fpbp_pkg::job_t               job_o,
  input  logic                         full_i
);
  import fpbp_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned PROD_W      = RECIP_SHIFT + PAGE_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

  logic [1:0]          state_q, state_d;
  logic                act_q, act_d;
  logic                err_q, err_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0]   rem_q, rem_d;
  logic [PAGE_W-1:0]   quo_q, quo_d;

  logic [ADDR_W:0]     end_addr;
  logic                bad;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   base;

  always_comb begin
    end_addr = {1'b0, s_address_i} + (ADDR_W + 1)'(s_count_i);
    bad      = (s_count_i > COUNT_W'(MAX_REQUEST)) ||
               (end_addr > (ADDR_W + 1)'(DEVICE_BYTES));
    prod     = PROD_W'(rem_q) * PROD_W'(RECIP);
    base     = ADDR_W'(quo_q) * ADDR_W'(PAGE_BYTES);
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    unique case (state_q)
      F_IDLE: begin
        if (s_valid_i) begin
          act_d = s_action_i;
          err_d = bad;
          cnt_d = s_count_i;
          rem_d = s_address_i;
          quo_d = '0;
          if (s_count_i == '0) begin
            state_d = F_IDLE;
          end else if (bad) begin
            state_d = F_PUSH;
          end else begin
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        quo_d   = prod[RECIP_SHIFT +: PAGE_W];
        state_d = F_MOD;
      end
      F_MOD: begin
        rem_d   = rem_q - base;
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    err_q <= err_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign s_ready_o    = (state_q == F_IDLE);
  assign push_o       = (state_q == F_PUSH) && !full_i;
  assign job_o.err    = err_q;
  assign job_o.act    = act_q;
  assign job_o.page   = quo_q;
  assign job_o.offset = rem_q[OFFSET_W-1:0];
  assign job_o.count  = cnt_q;

  `FPBP_ASSERT_IMP(a_offset_in_page, clk_i, rst_ni, push_o && !err_q, rem_q < ADDR_W'(PAGE_BYTES))

endmodule

@@ hdl/fpbp_queue.sv @@
// Short job queue between the front and back ends of the planner.
// Depends on fpbp_pkg for the job type and depth.
`include "flash_page_buffer_planner_defines.svh"

module fpbp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpbp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output fpbp_pkg::job_t data_o,
  output logic           empty_o
);
  import fpbp_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   used_q;

  assign full_o  = (used_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (used_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   used_q <= used_q + 1'b1;
        2'b01:   used_q <= used_q - 1'b1;
        default: used_q <= used_q;
      endcase
    end
  end

  `FPBP_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full_o)
  `FPBP_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o)

endmodule

@@ hdl/fpbp_back.sv @@
// Back end of the planner: keeps the buffer state and issues the command
// sequence of each job into an output register. Depends on fpbp_pkg.
`include "flash_page_buffer_planner_defines.svh"

module fpbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpbp_pkg::job_t    head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output fpbp_pkg::result_t m_result_o
);
  import fpbp_pkg::*;

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_ERR    = 4'd1;
  localparam logic [3:0] B_RFLUSH = 4'd2;
  localparam logic [3:0] B_READ   = 4'd3;
  localparam logic [3:0] B_WHEAD  = 4'd4;
  localparam logic [3:0] B_WFLUSH = 4'd5;
  localparam logic [3:0] B_WFILL  = 4'd6;
  localparam logic [3:0] B_WERASE = 4'd7;
  localparam logic [3:0] B_WBUF   = 4'd8;

  logic [3:0]          state_q, state_d;
  logic                active_q, active_d;
  logic [BPAGE_W-1:0]  bpage_q, bpage_d;
  logic                dirty_q, dirty_d;

  logic [BPAGE_W-1:0]  page_q, page_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [COUNT_W-1:0]  index_q, index_d;
  logic [COUNT_W-1:0]  chunk_q, chunk_d;

  logic                valid_q, valid_d;
  result_t             res_q, res_d;

  logic                can_emit;
  logic [COUNT_W:0]    sum;
  logic [COUNT_W-1:0]  chunk;
  logic [COUNT_W:0]    hsum;
  logic [1:0]          span;
  logic [BPAGE_W-1:0]  hpage;
  logic [BPAGE_W-1:0]  hi_page;
  logic                in_range;
  logic                wbuf_last;

  always_comb begin
    can_emit = !valid_q || m_ready_i;
    sum      = {1'b0, count_q} + (COUNT_W + 1)'(offset_q);
    chunk    = (sum > (COUNT_W + 1)'(PAGE_BYTES)) ?
               (COUNT_W'(PAGE_BYTES) - COUNT_W'(offset_q)) : count_q;
    hsum     = {1'b0, head_i.count} + (COUNT_W + 1)'(head_i.offset);
    if (hsum >= (COUNT_W + 1)'(2 * PAGE_BYTES)) begin
      span = 2'd2;
    end else if (hsum >= (COUNT_W + 1)'(PAGE_BYTES)) begin
      span = 2'd1;
    end else begin
      span = 2'd0;
    end
    hpage     = BPAGE_W'(head_i.page);
    hi_page   = hpage + BPAGE_W'(span);
    in_range  = dirty_q && (hpage <= bpage_q) && (bpage_q <= hi_page);
    wbuf_last = (count_q == chunk_q);
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    bpage_d  = bpage_q;
    dirty_d  = dirty_q;
    page_d   = page_q;
    offset_d = offset_q;
    count_d  = count_q;
    index_d  = index_q;
    chunk_d  = chunk_q;
    pop_o    = 1'b0;
    valid_d  = valid_q && !m_ready_i;
    res_d    = res_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          page_d   = hpage;
          offset_d = head_i.offset;
          count_d  = head_i.count;
          index_d  = '0;
          if (head_i.err) begin
            state_d = B_ERR;
          end else if (head_i.act) begin
            state_d = B_WHEAD;
          end else if (in_range) begin
            state_d = B_RFLUSH;
          end else begin
            state_d = B_READ;
          end
        end
      end
      B_ERR: begin
        if (can_emit) begin
          valid_d       = 1'b1;
          res_d         = '0;
          res_d.opcode  = OP_NONE;
          res_d.error   = 1'b1;
          res_d.last    = 1'b1;
          state_d       = B_IDLE;
        end
      end
      B_RFLUSH, B_WFLUSH: begin
        if (can_emit) begin
          valid_d      = 1'b1;
          res_d        = '0;
          res_d.opcode = active_q ? OP_FLUSH2 : OP_FLUSH1;
          res_d.page   = bpage_q[PAGE_W-1:0];
          dirty_d      = 1'b0;
          state_d      = (state_q == B_RFLUSH) ? B_READ : B_WHEAD;
        end
      end
      B_READ: begin
        if (can_emit) begin
          valid_d      = 1'b1;
          res_d        = '0;
          res_d.opcode = OP_READ_MEM;
          res_d.page   = page_q[PAGE_W-1:0];
          res_d.offset = offset_q;
          res_d.length = LENGTH_W'(count_q);
          res_d.last   = 1'b1;
          state_d      = B_IDLE;
        end
      end
      B_WHEAD: begin
        chunk_d = chunk;
        if (page_q != bpage_q) begin
          if (dirty_q) begin
            state_d = B_WFLUSH;
          end else begin
            active_d = !active_q;
            bpage_d  = page_q;
            state_d  = (chunk < COUNT_W'(PAGE_BYTES)) ? B_WFILL : B_WERASE;
          end
        end else begin
          state_d = B_WBUF;
        end
      end
      B_WFILL: begin
        if (can_emit) begin
          valid_d      = 1'b1;
          res_d        = '0;
          res_d.opcode = active_q ? OP_FILL2 : OP_FILL1;
          res_d.page   = page_q[PAGE_W-1:0];
          state_d      = B_WERASE;
        end
      end
      B_WERASE: begin
        if (can_emit) begin
          valid_d      = 1'b1;
          res_d        = '0;
          res_d.opcode = OP_ERASE;
          res_d.page   = page_q[PAGE_W-1:0];
          state_d      = B_WBUF;
        end
      end
      B_WBUF: begin
        if (can_emit) begin
          valid_d          = 1'b1;
          res_d            = '0;
          res_d.opcode     = active_q ? OP_WBUF2 : OP_WBUF1;
          res_d.offset     = offset_q;
          res_d.length     = LENGTH_W'(chunk_q);
          res_d.data_start = index_q[DSTART_W-1:0];
          res_d.last       = wbuf_last;
          dirty_d          = 1'b1;
          count_d          = count_q - chunk_q;
          index_d          = index_q + chunk_q;
          page_d           = page_q + 1'b1;
          offset_d         = '0;
          state_d          = wbuf_last ? B_IDLE : B_WHEAD;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      active_q <= 1'b0;
      bpage_q  <= BPAGE_W'(PAGE_COUNT);
      dirty_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      bpage_q  <= bpage_d;
      dirty_q  <= dirty_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    offset_q <= offset_d;
    count_q  <= count_d;
    index_q  <= index_d;
    chunk_q  <= chunk_d;
    res_q    <= res_d;
  end

  assign m_valid_o  = valid_q;
  assign m_result_o = res_q;

  `FPBP_ASSERT_IMP(a_error_is_last, clk_i, rst_ni, valid_q && res_q.error, res_q.last)
  `FPBP_ASSERT_IMP(a_chunk_nonzero, clk_i, rst_ni, state_q == B_WBUF, chunk_q != '0)
  `FPBP_ASSERT_NXT(a_wbuf_dirty, clk_i, rst_ni, state_q == B_WBUF && can_emit, dirty_q)

endmodule

@@ hdl/flash_page_buffer_planner.sv @@
// Command planner for a dual-buffer page flash with 264-byte pages. A request
// (read or write, byte address, byte count) becomes its ordered list of device
// commands: buffer fill, flush, page erase, buffer write and memory read. The
// front end checks the request against the device end and the maximum length,
// then splits the address into page and offset by a reciprocal multiplication
// followed by a multiply-back and subtract, in accept, quotient, remainder and
// hand-off states (a rejected request skips quotient and remainder), taking a
// new request only once the last is handed off. A two-entry job queue feeds
// the back end, which issues one command per cycle while the output register
// drains, apart from the idle state that takes each job and a decision state
// before each write chunk and after each write flush; a request yields up to 11
// commands, and the sustained rate is set by the slower of the front end and
// the command sequence. Requests of zero bytes produce no command. Reset clears
// the buffer state (buffer one active, no page buffered, clean) and needs no
// clearing pass. Depends on fpbp_pkg, fpbp_front, fpbp_queue and fpbp_back.

module flash_page_buffer_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address [19:0], count [29:20], zero fill
  input  logic [0:0]  s_axis_tuser,   // action [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // opcode [7:0], page [18:8], offset [27:19],
                                      // length [37:28], data_start [46:38], zero fill
  output logic [0:0]  m_axis_tuser,   // error [0]
  output logic        m_axis_tlast
);
  import fpbp_pkg::*;

  logic    push;
  logic    full;
  job_t    push_job;
  job_t    head_job;
  logic    empty;
  logic    pop;
  result_t result;

  fpbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_action_i  (s_axis_tuser[0]),
    .s_address_i (s_axis_tdata[ADDR_W-1:0]),
    .s_count_i   (s_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W]),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  fpbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (empty)
  );

  fpbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_job),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  assign m_axis_tdata = {1'b0, result.data_start, result.length, result.offset,
                         result.page, result.opcode};
  assign m_axis_tuser = result.error;
  assign m_axis_tlast = result.last;

endmodule
